// ----- sv/edd_pkg.sv -----
// Shared constants, types and arithmetic helpers for the error diffusion ditherer.
package edd_pkg;

  localparam int MAX_WIDTH_DEFAULT = 1024;

  localparam int PIXEL_W           = 8;
  localparam int IMAGE_WIDTH_W     = 11;
  localparam int IMAGE_HEIGHT_W    = 16;
  localparam int IMAGE_WIDTH_RESET = 1024;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] OP_PUSH      = 2'd0;
  localparam logic [1:0] OP_PUSH_EMIT = 2'd1;
  localparam logic [1:0] OP_FLUSH     = 2'd2;

  localparam logic [PIXEL_W-1:0] WHITE_THRESHOLD = 8'd128;
  localparam logic [PIXEL_W-1:0] WHITE_LEVEL     = 8'd255;

  localparam logic [2:0] WEIGHT_RIGHT       = 3'd7;
  localparam logic [2:0] WEIGHT_BELOW_LEFT  = 3'd3;
  localparam logic [2:0] WEIGHT_BELOW       = 3'd5;
  localparam logic [2:0] WEIGHT_BELOW_RIGHT = 3'd1;

  localparam int MID_DEPTH_DEFAULT = 4;
  localparam int OUT_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [1:0]         op;
    logic [PIXEL_W-1:0] gray;
  } cmd_t;

  typedef struct packed {
    logic dot_white;
    logic frame_end;
  } res_t;

  // Add a signed share to a level, clamp to 0..255.
  function automatic logic [PIXEL_W-1:0] sat_add(input logic [PIXEL_W-1:0] base,
                                                 input logic signed [7:0] delta);
    logic signed [9:0] sum;
    sum = $signed({2'b00, base}) + 10'(delta);
    if (sum > 10'sd255) begin
      return WHITE_LEVEL;
    end else if (sum < 10'sd0) begin
      return '0;
    end else begin
      return sum[PIXEL_W-1:0];
    end
  endfunction

  // err * weight / 16, truncated toward zero.
  function automatic logic signed [7:0] share(input logic signed [7:0] err,
                                              input logic [2:0] weight);
    logic signed [11:0] prod;
    logic signed [11:0] quot;
    prod = 12'(err) * $signed({9'd0, weight});
    if (prod < 12'sd0) begin
      prod = prod + 12'sd15;
    end
    quot = prod >>> 4;
    return quot[7:0];
  endfunction

endpackage

// ----- sv/edd_fifo.sv -----
// Small register queue used between the front, the back and the result port.
module edd_fifo #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [NW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= bump(wptr);
      end
      if (do_rd) begin
        rptr <= bump(rptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- sv/edd_front.sv -----
// Front end: accepts requests, tracks the pending count and classifies each request.
module edd_front import edd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int PW = $clog2(MAX_WIDTH + 3)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [WW-1:0]      width,
  input  logic               push,
  input  logic               command,
  input  logic [PIXEL_W-1:0] gray,
  output logic               full,
  input  logic               q_full,
  output logic               q_write,
  output cmd_t               q_cmd,
  output logic [PW-1:0]      q_pend
);

  localparam int CW = $clog2(MAX_WIDTH + 5);

  logic [PW-1:0] pend;
  logic [PW-1:0] pend_next;
  logic [PW-1:0] pend_inc;
  logic          accept;
  logic          line_full;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign pend_inc  = pend + 1'b1;
  // Window holds width+2 pixels: the oldest one must go out now.
  assign line_full = (CW'(pend_inc) == CW'(width) + CW'(2));

  always_comb begin
    q_write    = 1'b0;
    q_cmd.op   = OP_PUSH;
    q_cmd.gray = gray;
    q_pend     = pend_inc;
    pend_next  = pend;
    if (accept) begin
      case (command)
        CMD_PIXEL: begin
          q_write = 1'b1;
          q_pend  = pend_inc;
          if (line_full) begin
            q_cmd.op  = OP_PUSH_EMIT;
            pend_next = pend;
          end else begin
            q_cmd.op  = OP_PUSH;
            pend_next = pend_inc;
          end
        end
        CMD_FLUSH: begin
          // drop a flush with nothing pending
          if (pend != '0) begin
            q_write   = 1'b1;
            q_cmd.op  = OP_FLUSH;
            q_pend    = pend;
            pend_next = pend - 1'b1;
          end
        end
        default: begin
          pend_next = pend;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pend <= '0;
    end else begin
      pend <= pend_next;
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(pend) <= CW'(width) + CW'(1))
    else $error("pending count exceeds width+1");

  a_pend_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(restart) |->
      (pend == $past(pend)) || (pend == $past(pend) + 1'b1) ||
      (pend + 1'b1 == $past(pend)))
    else $error("pending count moved by more than one");

  a_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_write |-> accept)
    else $error("queue written without an accepted request");

endmodule

// ----- sv/edd_back.sv -----
// Back end: line memory, head window and per-dot error diffusion.
module edd_back import edd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int PW = $clog2(MAX_WIDTH + 3)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic [WW-1:0]             width,
  input  logic [IMAGE_HEIGHT_W-1:0] height_last,
  input  logic                      in_valid,
  input  cmd_t                      in_cmd,
  input  logic [PW-1:0]             in_pend,
  output logic                      in_take,
  input  logic                      out_ready,
  output logic                      out_write,
  output res_t                      out_res
);

  localparam int CW  = $clog2(MAX_WIDTH + 5);
  localparam int MAW = $clog2(MAX_WIDTH);

  logic [PIXEL_W-1:0] mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] mem_q;
  logic [MAW-1:0]     wp;
  logic [MAW-1:0]     rp;
  logic [MAW-1:0]     wp_next;
  logic [MAW-1:0]     rp_next;

  logic [PIXEL_W-1:0] head      [3];
  logic [PIXEL_W-1:0] head_sh   [3];
  logic [PIXEL_W-1:0] head_next [3];

  logic signed [7:0]  carry;
  logic               carry_valid;
  logic [WW-1:0]      col;
  logic [IMAGE_HEIGHT_W-1:0] row;

  logic               adv;
  logic               is_push;
  logic               is_emit;
  logic               evict;
  logic               from_evict;
  logic               from_head;
  logic [PW-1:0]      pend_m1;
  logic [PIXEL_W-1:0] src;
  logic [PIXEL_W-1:0] level;
  logic               white;
  logic signed [8:0]  err9;
  logic signed [7:0]  err;
  logic [WW-1:0]      wm1;
  logic               last_col;
  logic               last_row;
  logic               diffuse;
  logic signed [7:0]  s7;
  logic signed [7:0]  s3;
  logic signed [7:0]  s5;
  logic signed [7:0]  s1;
  logic [4:0]         eq;

  function automatic logic [MAW-1:0] bump(input logic [MAW-1:0] p);
    return (p == MAW'(MAX_WIDTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign adv     = in_valid && out_ready;
  assign in_take = adv;

  always_comb begin
    case (in_cmd.op)
      OP_PUSH: begin
        is_push = 1'b1;
        is_emit = 1'b0;
      end
      OP_PUSH_EMIT: begin
        is_push = 1'b1;
        is_emit = 1'b1;
      end
      OP_FLUSH: begin
        is_push = 1'b0;
        is_emit = 1'b1;
      end
      default: begin
        is_push = 1'b0;
        is_emit = 1'b0;
      end
    endcase
  end

  // Three newest pixels live in head; older ones spill into the memory.
  assign evict      = is_push && (in_pend >= PW'(4));
  assign from_evict = is_push && (in_pend == PW'(4));
  assign from_head  = (in_pend <= PW'(3));
  assign pend_m1    = in_pend - 1'b1;

  always_comb begin
    if (is_push) begin
      head_sh[0] = in_cmd.gray;
      head_sh[1] = head[0];
      head_sh[2] = head[1];
    end else begin
      head_sh[0] = head[0];
      head_sh[1] = head[1];
      head_sh[2] = head[2];
    end
  end

  always_comb begin
    if (from_head) begin
      src = head_sh[pend_m1[1:0]];
    end else if (from_evict) begin
      src = head[2];
    end else begin
      src = mem_q;
    end
  end

  assign level = carry_valid ? sat_add(src, carry) : src;
  assign white = (level >= WHITE_THRESHOLD);
  assign err9  = $signed({1'b0, level}) - (white ? $signed({1'b0, WHITE_LEVEL}) : 9'sd0);
  assign err   = err9[7:0];

  assign wm1      = width - 1'b1;
  assign last_col = (col == wm1);
  assign last_row = (row == height_last);
  assign diffuse  = !last_row && (col != '0) && !last_col;

  assign s7 = share(err, WEIGHT_RIGHT);
  assign s3 = share(err, WEIGHT_BELOW_LEFT);
  assign s5 = share(err, WEIGHT_BELOW);
  assign s1 = share(err, WEIGHT_BELOW_RIGHT);

  // eq[j]: pending == width + j, locating the row-below targets in head.
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      eq[j] = (CW'(in_pend) == CW'(width) + CW'(j));
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      head_next[k] = head_sh[k];
      if (is_emit && diffuse) begin
        if (eq[k]) begin
          head_next[k] = sat_add(head_sh[k], s3);
        end else if (eq[k+1]) begin
          head_next[k] = sat_add(head_sh[k], s5);
        end else if (eq[k+2]) begin
          head_next[k] = sat_add(head_sh[k], s1);
        end
      end
    end
  end

  always_comb begin
    if (restart) begin
      wp_next = '0;
      rp_next = '0;
    end else begin
      wp_next = (adv && evict) ? bump(wp) : wp;
      rp_next = (adv && is_emit && !from_head) ? bump(rp) : rp;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && evict) begin
      mem[wp] <= head[2];
    end
    if (adv && evict && (wp == rp_next)) begin
      mem_q <= head[2];
    end else begin
      mem_q <= mem[rp_next];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head[0] <= head_next[0];
      head[1] <= head_next[1];
      head[2] <= head_next[2];
    end
    if (adv && is_emit) begin
      carry <= s7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp          <= '0;
      rp          <= '0;
      carry_valid <= 1'b0;
      col         <= '0;
      row         <= '0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
      if (restart) begin
        carry_valid <= 1'b0;
        col         <= '0;
        row         <= '0;
      end else if (adv && is_emit) begin
        carry_valid <= diffuse && (in_pend > PW'(1));
        if (last_col) begin
          col <= '0;
          row <= last_row ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  assign out_write         = adv && is_emit;
  assign out_res.dot_white = white;
  assign out_res.frame_end = last_row && last_col;

  a_mem_nonempty: assert property (@(posedge clk) disable iff (rst)
    adv && is_emit && !from_head && !from_evict |-> (wp != rp))
    else $error("dot read from an empty line memory");

  a_emit_pending: assert property (@(posedge clk) disable iff (rst)
    adv && is_emit |-> (in_pend != '0))
    else $error("dot emitted with nothing pending");

  a_frame_end_no_carry: assert property (@(posedge clk) disable iff (rst)
    adv && is_emit && out_res.frame_end |=> !carry_valid)
    else $error("error carried past the last dot of a frame");

endmodule

// ----- sv/error_diffusion_dither.sv -----
// Top level of the error diffusion ditherer: configuration, front, queues and back.
// Release: the back writes a dot to the result queue once the request that releases it
//   (the pixel width+1 places later, or a flush request) has passed through the mid queue.
// Throughput: one request per cycle while no queue is full, set by the update of the
//   three-pixel head window and one line-memory write plus one read per cycle.
// Reset: control state and pointers clear at once; the line memory is not cleared and
//   needs no clearing pass. Width resets to 1024 (clamped to MAX_WIDTH), height to 1.
module error_diffusion_dither import edd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  parameter int MID_DEPTH = MID_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // pixel / flush requests
  input  logic                   push,
  output logic                   full,
  input  logic                   command,
  input  logic [PIXEL_W-1:0]     gray,
  // dithered dots
  output logic                   empty,
  input  logic                   pop,
  output logic                   dot_white,
  output logic                   frame_end,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int PW      = $clog2(MAX_WIDTH + 3);
  localparam int MID_W   = $bits(cmd_t) + PW;
  localparam int OUT_W   = $bits(res_t);
  localparam int RESET_W = (IMAGE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : IMAGE_WIDTH_RESET;

  // Effective geometry: width clamped to 1..MAX_WIDTH, height held as its last row.
  logic [WW-1:0]             width;
  logic [IMAGE_HEIGHT_W-1:0] height_last;
  logic [IMAGE_WIDTH_W-1:0]  width_raw;
  logic [IMAGE_HEIGHT_W-1:0] height_raw;
  logic [WW-1:0]             width_clamped;
  logic                      restart;

  // front -> mid queue
  logic                      front_write;
  cmd_t                      front_cmd;
  logic [PW-1:0]             front_pend;
  logic                      mid_full;
  logic                      mid_empty;
  logic [MID_W-1:0]          mid_rdata;
  cmd_t                      mid_cmd;
  logic [PW-1:0]             mid_pend;
  logic                      mid_take;

  // back -> result queue
  logic                      back_write;
  res_t                      back_res;
  logic                      out_full;
  logic [OUT_W-1:0]          out_rdata;
  res_t                      out_res;

  // Configuration is always taken; any register write restarts the stream.
  assign cfg_ready  = 1'b1;
  assign width_raw  = cfg_data[IMAGE_WIDTH_W-1:0];
  assign height_raw = cfg_data[IMAGE_HEIGHT_W-1:0];
  assign restart    = cfg_valid && cfg_ready &&
                      ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

  always_comb begin
    if (width_raw == '0) begin
      width_clamped = WW'(1);
    end else if (32'(width_raw) > MAX_WIDTH) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(width_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width       <= WW'(RESET_W);
      height_last <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          width <= width_clamped;
        end
        REG_IMAGE_HEIGHT: begin
          // height zero acts as one row
          height_last <= (height_raw == '0) ? '0 : height_raw - 1'b1;
        end
        default: begin
          width <= width;
        end
      endcase
    end
  end

  // Front: take requests, count pending pixels, tag each request with its action.
  edd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .width   (width),
    .push    (push),
    .command (command),
    .gray    (gray),
    .full    (full),
    .q_full  (mid_full),
    .q_write (front_write),
    .q_cmd   (front_cmd),
    .q_pend  (front_pend)
  );

  // Hold classified requests so front and back stall independently.
  edd_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (front_write),
    .wdata ({front_cmd, front_pend}),
    .full  (mid_full),
    .rd    (mid_take),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign {mid_cmd, mid_pend} = mid_rdata;

  // Back: advance the line window and diffuse error for each emitted dot.
  edd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .width       (width),
    .height_last (height_last),
    .in_valid    (!mid_empty),
    .in_cmd      (mid_cmd),
    .in_pend     (mid_pend),
    .in_take     (mid_take),
    .out_ready   (!out_full),
    .out_write   (back_write),
    .out_res     (back_res)
  );

  // Result queue parts the back from the consumer.
  edd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (back_write),
    .wdata (back_res),
    .full  (out_full),
    .rd    (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_res   = out_rdata;
  assign dot_white = out_res.dot_white;
  assign frame_end = out_res.frame_end;

endmodule

// ----- tb/tb_error_diffusion_dither.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the error diffusion ditherer: directed table, then random frames.
module tb_error_diffusion_dither;
  import edd_pkg::*;

  // Geometry and arithmetic of the dither, kept apart from the RTL package but for MAX_W
  localparam int MAX_W             = MAX_WIDTH_DEFAULT;
  localparam int WIDTH_AT_RESET    = 1024;
  localparam int HEIGHT_AT_RESET   = 1;
  localparam int MID_GRAY          = 128;
  localparam int FULL_WHITE        = 255;
  localparam int SHARE_RIGHT       = 7;
  localparam int SHARE_BELOW_LEFT  = 3;
  localparam int SHARE_BELOW       = 5;
  localparam int SHARE_BELOW_RIGHT = 1;
  localparam int SHARE_DIV         = 16;

  // Run shape
  localparam int SETTLE_CYCLES   = 8;     // settle time once every predicted dot is in
  localparam int RANDOM_REQUESTS = 300;   // small frames; the wide line adds about 1100
  localparam int REPORT_LIMIT    = 10;
  localparam int CYCLE_NS        = 20;

  typedef enum {ROW_PIXEL, ROW_FLUSH, ROW_WIDTH, ROW_HEIGHT} row_kind_t;
  // How a directed row's dot is known: from the predictor, or typed in
  typedef enum {
    WANT_MODEL, WANT_NONE, WANT_BLACK, WANT_WHITE, WANT_BLACK_LAST, WANT_WHITE_LAST
  } want_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_DATA_W-1:0] value;
    want_t                 want;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  logic                   command;
  logic [PIXEL_W-1:0]     gray;
  logic                   empty;
  logic                   pop;
  logic                   dot_white;
  logic                   frame_end;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  error_diffusion_dither i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .gray      (gray),
    .empty     (empty),
    .pop       (pop),
    .dot_white (dot_white),
    .frame_end (frame_end),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Dither predictor: its own ring of pending levels, dot position and registers
  // ---------------------------------------------------------------------------
  logic [PIXEL_W-1:0]        line_ring [MAX_W+2];
  int unsigned               ring_wr;
  int unsigned               ring_pending;
  int unsigned               dot_col;
  int unsigned               dot_row;
  logic [IMAGE_WIDTH_W-1:0]  width_reg;
  logic [IMAGE_HEIGHT_W-1:0] height_reg;

  res_t dots_due [$];   // dots predicted, oldest first
  row_t plan [$];       // directed stimulus table

  bit          push_up;
  bit          tx_steady;
  bit          rx_steady;
  int unsigned requests_sent;
  int unsigned flushes_sent;
  int unsigned dots_checked;
  int unsigned frames_seen;
  int unsigned settings_used;
  int unsigned bad_dots;

  // Width 0 runs as 1, anything past the line buffer runs as its size
  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // A register write drops all pending levels and returns to the top-left dot
  function automatic void restart_stream();
    foreach (line_ring[i]) line_ring[i] = '0;
    ring_wr      = 0;
    ring_pending = 0;
    dot_col      = 0;
    dot_row      = 0;
  endfunction

  function automatic logic [PIXEL_W-1:0] clamp_add(input logic [PIXEL_W-1:0] level,
                                                   input int delta);
    int s;
    s = int'(level) + delta;
    if (s > FULL_WHITE) return PIXEL_W'(FULL_WHITE);
    if (s < 0) return '0;
    return PIXEL_W'(s);
  endfunction

  // Decide the oldest pending level and spread its error over the pixels already held
  function automatic res_t decide_oldest();
    int unsigned w;
    int unsigned h;
    int unsigned ring;
    int unsigned rd;
    int unsigned slot;
    int unsigned k;
    int          err;
    int unsigned reach [4];
    int          weight [4];
    res_t        dot;
    w      = active_width();
    h      = active_height();
    ring   = w + 2;
    reach  = '{1, w - 1, w, w + 1};
    weight = '{SHARE_RIGHT, SHARE_BELOW_LEFT, SHARE_BELOW, SHARE_BELOW_RIGHT};
    rd     = (ring_wr + ring - ring_pending) % ring;
    dot.dot_white = (line_ring[rd] >= MID_GRAY);
    err = int'(line_ring[rd]) - (dot.dot_white ? FULL_WHITE : 0);
    // Last row and both edge columns keep their error
    if (dot_row != h - 1 && dot_col != 0 && dot_col != w - 1) begin
      for (k = 0; k < 4; k++) begin
        // drop shares aimed at pixels that have not arrived yet
        if (reach[k] < ring_pending) begin
          slot = (rd + reach[k]) % ring;
          line_ring[slot] = clamp_add(line_ring[slot], (err * weight[k]) / SHARE_DIV);
        end
      end
    end
    dot.frame_end = (dot_row == h - 1) && (dot_col == w - 1);
    dot_col++;
    if (dot_col >= w) begin
      dot_col = 0;
      dot_row++;
      if (dot_row >= h) dot_row = 0;
    end
    ring_pending--;
    return dot;
  endfunction

  // Advance the predictor by one accepted request; return 1 when it releases a dot
  function automatic bit predict_dot(input logic cmd, input logic [PIXEL_W-1:0] level,
                                     output res_t dot);
    int unsigned w;
    w   = active_width();
    dot = '0;
    if (cmd == CMD_FLUSH) begin
      if (ring_pending == 0) return 0;
      dot = decide_oldest();
      return 1;
    end
    line_ring[ring_wr] = level;
    ring_wr = (ring_wr + 1) % (w + 2);
    ring_pending++;
    if (ring_pending > w + 1) begin
      dot = decide_oldest();
      return 1;
    end
    return 0;
  endfunction

  function automatic void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) width_reg = data[IMAGE_WIDTH_W-1:0];
    else height_reg = data[IMAGE_HEIGHT_W-1:0];
    restart_stream();
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  // Mostly back to back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Lean on the extremes and on levels around the threshold
  function automatic logic [PIXEL_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 8'd0 : 8'd255;
      1:       return ($urandom_range(0, 1) != 0) ? 8'd127 : 8'd128;
      2, 3:    return PIXEL_W'($urandom_range(96, 160));
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  function automatic void plan_row(input row_kind_t kind, input logic [CFG_DATA_W-1:0] value,
                                   input want_t want);
    row_t row;
    row.kind  = kind;
    row.value = value;
    row.want  = want;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request, hold it until accepted, then predict its dot
  task automatic send_request(input logic cmd, input logic [PIXEL_W-1:0] level,
                              input want_t want);
    res_t        dot;
    bit          has_dot;
    int unsigned gap;
    push    <= 1'b1;
    command <= cmd;
    gray    <= level;
    push_up  = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    has_dot = predict_dot(cmd, level, dot);
    // typed-in rows override the predicted dot; the predictor still advances
    if (want != WANT_MODEL) begin
      has_dot       = (want != WANT_NONE);
      dot.dot_white = (want == WANT_WHITE) || (want == WANT_WHITE_LAST);
      dot.frame_end = (want == WANT_BLACK_LAST) || (want == WANT_WHITE_LAST);
    end
    if (has_dot) dots_due.push_back(dot);
    requests_sent++;
    if (cmd == CMD_FLUSH) flushes_sent++;
    gap = tx_steady ? 0 : pick_gap();
    if (gap != 0) begin
      push   <= 1'b0;
      push_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop push if the last request left it high
  task automatic release_push();
    if (push_up) begin
      push   <= 1'b0;
      push_up = 1'b0;
    end
  endtask

  // Hold off until every predicted dot is in, then let the pipeline settle
  task automatic wait_quiet();
    release_push();
    while (dots_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    set_register(idx, data);
  endtask

  // One random setting followed by whole frames of random levels, with stray
  // flushes inside frames, partial frames and an optional drain at the end
  task automatic random_phase(input bit wide);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    int unsigned           w;
    int unsigned           h;
    int unsigned           r;
    int unsigned           npix;
    int unsigned           k;
    bit                    put_width;
    bit                    put_height;
    if (wide) begin
      w = ($urandom_range(0, 1) != 0) ? MAX_W : 2047;
      h = 2;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) w = $urandom_range(1, 6);
      else if (r < 90) w = $urandom_range(7, 40);
      else w = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 70) h = $urandom_range(1, 4);
      else if (r < 80) h = 0;
      else if (r < 92) h = $urandom_range(5, 12);
      else h = $urandom_range(0, 65535);
    end
    // spare bits above the width field carry noise
    wdata = CFG_DATA_W'($urandom);
    wdata[IMAGE_WIDTH_W-1:0] = IMAGE_WIDTH_W'(w);
    hdata = CFG_DATA_W'(h);
    put_width  = wide || ($urandom_range(0, 5) != 0);
    put_height = wide || ($urandom_range(0, 5) != 0);
    if (!put_width && !put_height) put_width = 1'b1;
    if ($urandom_range(0, 1) != 0) begin
      if (put_width) write_register(REG_IMAGE_WIDTH, wdata);
      if (put_height) write_register(REG_IMAGE_HEIGHT, hdata);
    end else begin
      if (put_height) write_register(REG_IMAGE_HEIGHT, hdata);
      if (put_width) write_register(REG_IMAGE_WIDTH, wdata);
    end
    settings_used++;
    tx_steady = ($urandom_range(0, 3) == 0);

    w = active_width();
    h = active_height();
    if (wide) begin
      // just past one line so dots leave through the normal path too
      npix = w + $urandom_range(2, 40);
    end else begin
      npix = w * h * $urandom_range(1, 3);
      if (npix > 200) npix = $urandom_range(w + 2, 200);
      if ($urandom_range(0, 3) == 0) npix += $urandom_range(1, w);
    end
    for (k = 0; k < npix; k++) begin
      if ($urandom_range(0, 15) == 0) send_request(CMD_FLUSH, PIXEL_W'($urandom), WANT_MODEL);
      send_request(CMD_PIXEL, pick_level(), WANT_MODEL);
    end
    // Small frames usually drain, sometimes with extra flushes on an empty block,
    // otherwise leave pixels pending for the next register write to drop;
    // the wide line flushes only a few dots out of the line memory
    if (wide) begin
      repeat ($urandom_range(2, 40))
        send_request(CMD_FLUSH, PIXEL_W'($urandom), WANT_MODEL);
    end else if ($urandom_range(0, 4) != 0) begin
      repeat (ring_pending + $urandom_range(0, 2))
        send_request(CMD_FLUSH, PIXEL_W'($urandom), WANT_MODEL);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Dot side
  // ---------------------------------------------------------------------------
  task automatic check_dot();
    res_t want_dot;
    if (dots_due.size() == 0) begin
      bad_dots++;
      if (bad_dots <= REPORT_LIMIT)
        $display("%0t: dot with none due: white=%0b last=%0b", $realtime, dot_white, frame_end);
      return;
    end
    want_dot = dots_due.pop_front();
    dots_checked++;
    if (frame_end === 1'b1) frames_seen++;
    if (dot_white !== want_dot.dot_white || frame_end !== want_dot.frame_end) begin
      bad_dots++;
      if (bad_dots <= REPORT_LIMIT)
        $display("%0t: dot %0d wrong: expected white=%0b last=%0b, got white=%0b last=%0b",
                 $realtime, dots_checked, want_dot.dot_white, want_dot.frame_end,
                 dot_white, frame_end);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #(CYCLE_NS / 2) clk = ~clk;
  end

  // Take dots with random stalls; now and then switch to taking every cycle
  initial begin : dot_receiver
    int unsigned stall;
    stall     = 0;
    rx_steady = 1'b0;
    pop      <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_dot();
      if (stall != 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall = pick_gap();
      end
      if ($urandom_range(0, 499) == 0) rx_steady = !rx_steady;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned directed_count;
    rst       <= 1'b1;
    push      <= 1'b0;
    command   <= CMD_PIXEL;
    gray      <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= '0;
    push_up       = 1'b0;
    tx_steady     = 1'b0;
    requests_sent = 0;
    flushes_sent  = 0;
    dots_checked  = 0;
    frames_seen   = 0;
    settings_used = 0;
    bad_dots      = 0;
    width_reg     = IMAGE_WIDTH_W'(WIDTH_AT_RESET);
    height_reg    = IMAGE_HEIGHT_W'(HEIGHT_AT_RESET);
    restart_stream();

    // Reset setting: one row of 1024, one row high. Column 0 never ends the
    // frame, and a single row spreads no error.
    plan_row(ROW_FLUSH, 16'd0,   WANT_NONE);        // nothing pending yet
    plan_row(ROW_PIXEL, 16'd200, WANT_NONE);
    plan_row(ROW_PIXEL, 16'd50,  WANT_NONE);
    plan_row(ROW_FLUSH, 16'd0,   WANT_WHITE);
    plan_row(ROW_FLUSH, 16'd0,   WANT_BLACK);
    plan_row(ROW_FLUSH, 16'd0,   WANT_NONE);
    // Zero width and height run as a 1x1 frame: plain threshold, every dot ends a frame
    plan_row(ROW_WIDTH,  16'd0, WANT_MODEL);
    plan_row(ROW_HEIGHT, 16'd0, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd0,   WANT_NONE);
    plan_row(ROW_PIXEL, 16'd255, WANT_NONE);
    plan_row(ROW_PIXEL, 16'd127, WANT_BLACK_LAST);
    plan_row(ROW_PIXEL, 16'd128, WANT_WHITE_LAST);
    plan_row(ROW_FLUSH, 16'd0,   WANT_BLACK_LAST);
    plan_row(ROW_FLUSH, 16'd0,   WANT_WHITE_LAST);
    // All-ones writes: width clamps to the line buffer, tallest frame;
    // leave a pixel pending for the next write to drop
    plan_row(ROW_WIDTH,  16'hFFFF, WANT_MODEL);
    plan_row(ROW_HEIGHT, 16'hFFFF, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd255, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd0,   WANT_MODEL);
    plan_row(ROW_FLUSH, 16'hFFFF, WANT_MODEL);
    // 3x2 frame: the middle column of the top row diffuses
    plan_row(ROW_WIDTH,  16'd3, WANT_MODEL);
    plan_row(ROW_HEIGHT, 16'd2, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd200, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd100, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd60,  WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd250, WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd10,  WANT_MODEL);
    plan_row(ROW_PIXEL, 16'd130, WANT_MODEL);
    repeat (4) plan_row(ROW_FLUSH, 16'd0, WANT_MODEL);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WIDTH:  write_register(REG_IMAGE_WIDTH, plan[i].value);
        ROW_HEIGHT: write_register(REG_IMAGE_HEIGHT, plan[i].value);
        ROW_FLUSH:  send_request(CMD_FLUSH, plan[i].value[PIXEL_W-1:0], plan[i].want);
        default:    send_request(CMD_PIXEL, plan[i].value[PIXEL_W-1:0], plan[i].want);
      endcase
    end
    directed_count = requests_sent;

    // Mostly small frames, then one pass at the widest line
    while (requests_sent < directed_count + RANDOM_REQUESTS) random_phase(1'b0);
    random_phase(1'b1);

    wait_quiet();
    $display("Covered %0d requests (%0d flushes) over %0d random settings;",
             requests_sent, flushes_sent, settings_used);
    $display("checked %0d dots, %0d of them frame ends, %0d wrong.",
             dots_checked, frames_seen, bad_dots);
    if (bad_dots == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d dots still due.", dots_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- error_diffusion_dither.f -----
sv/edd_pkg.sv
sv/edd_fifo.sv
sv/edd_front.sv
sv/edd_back.sv
sv/error_diffusion_dither.sv
tb/tb_error_diffusion_dither.sv
